// ===== rtl/core/tpbm_pkg.sv =====
// Package: types, constants and microcode ROM of the tape pulse byte modulator
package tpbm_pkg;

  localparam int unsigned CountWidth = 20;
  localparam int unsigned CfgIndexWidth = 3;

  localparam logic [CfgIndexWidth-1:0] CfgPulseHalf  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgOneGap     = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgZeroGap    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgPulsesOne  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgPulsesZero = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CfgBytePause  = 3'd5;
  localparam logic [CfgIndexWidth-1:0] CfgBlockPause = 3'd6;

  localparam logic signed [1:0] LvlNeg  = -2'sd1;
  localparam logic signed [1:0] LvlZero = 2'sd0;
  localparam logic signed [1:0] LvlPos  = 2'sd1;

  localparam logic [2:0] LastBit = 3'd7;

  typedef enum logic [2:0] {
    STEP_FETCH  = 3'd0,
    STEP_BPAUSE = 3'd1,
    STEP_NEG    = 3'd2,
    STEP_POS    = 3'd3,
    STEP_GAP    = 3'd4,
    STEP_BLK    = 3'd5
  } step_t;

  typedef enum logic [2:0] {
    LEN_PULSE,
    LEN_GAP,
    LEN_BYTE_PAUSE,
    LEN_BLOCK_PAUSE
  } len_sel_t;

  typedef enum logic [1:0] {
    LAST_NEVER,
    LAST_ALWAYS,
    LAST_BYTE_END
  } last_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_DISPATCH,
    JMP_BIT_LOOP
  } jump_t;

  typedef struct packed {
    logic             emit;
    logic signed [1:0] level;
    len_sel_t         len_sel;
    last_sel_t        last_sel;
    jump_t            jump;
    step_t            target;
  } ctrl_t;

  typedef struct packed {
    logic [CountWidth-1:0] pulse_half;
    logic [CountWidth-1:0] one_gap;
    logic [CountWidth-1:0] zero_gap;
    logic [1:0]            pulses_one;
    logic [1:0]            pulses_zero;
    logic [CountWidth-1:0] byte_pause;
    logic [CountWidth-1:0] block_pause;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic signed [1:0]     level;
    logic [CountWidth-1:0] run_length;
    logic                  last;
  } seg_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t cw;
    unique case (step)
      STEP_FETCH:  cw = '{1'b0, LvlZero, LEN_PULSE,       LAST_NEVER,    JMP_DISPATCH, STEP_FETCH};
      STEP_BPAUSE: cw = '{1'b1, LvlZero, LEN_BYTE_PAUSE,  LAST_NEVER,    JMP_NEXT,     STEP_NEG};
      STEP_NEG:    cw = '{1'b1, LvlNeg,  LEN_PULSE,       LAST_NEVER,    JMP_NEXT,     STEP_POS};
      STEP_POS:    cw = '{1'b1, LvlPos,  LEN_PULSE,       LAST_NEVER,    JMP_NEXT,     STEP_GAP};
      STEP_GAP:    cw = '{1'b1, LvlZero, LEN_GAP,         LAST_BYTE_END, JMP_BIT_LOOP, STEP_NEG};
      STEP_BLK:    cw = '{1'b1, LvlZero, LEN_BLOCK_PAUSE, LAST_ALWAYS,   JMP_NEXT,     STEP_FETCH};
      default:     cw = '{1'b0, LvlZero, LEN_PULSE,       LAST_NEVER,    JMP_NEXT,     STEP_FETCH};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/core/tpbm_useq.sv =====
// Microcoded sequencer and bit datapath that turn one item into segments
module tpbm_useq (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_func,
  input  logic [7:0]          item_byte,
  input  logic                item_block_start,
  output logic                item_ready,
  input  tpbm_pkg::cfg_t      cfg,
  input  logic                seg_free,
  output tpbm_pkg::seg_t      seg
);

  tpbm_pkg::step_t step;
  tpbm_pkg::step_t step_next;
  tpbm_pkg::ctrl_t cw;
  logic [7:0]      byte_sr;
  logic [2:0]      bit_cnt;
  logic            more;
  logic            fire;
  logic            byte_end;
  logic            take;

  assign cw       = tpbm_pkg::ucode(step);
  assign byte_end = !more && (bit_cnt == tpbm_pkg::LastBit);
  assign fire     = cw.emit && seg_free;
  assign take     = item_ready && item_valid;

  always_comb begin
    step_next = step;
    if (cw.jump == tpbm_pkg::JMP_DISPATCH) begin
      if (item_valid) begin
        if (item_func) begin
          step_next = tpbm_pkg::STEP_BLK;
        end else if (item_block_start) begin
          step_next = tpbm_pkg::STEP_NEG;
        end else begin
          step_next = tpbm_pkg::STEP_BPAUSE;
        end
      end
    end else if (fire) begin
      unique case (cw.jump)
        tpbm_pkg::JMP_BIT_LOOP: step_next = byte_end ? tpbm_pkg::STEP_FETCH : cw.target;
        default:                step_next = cw.target;
      endcase
    end
  end

  always_comb begin
    item_ready     = (cw.jump == tpbm_pkg::JMP_DISPATCH);
    seg.valid      = fire;
    seg.level      = cw.level;
    seg.run_length = cfg.pulse_half;
    unique case (cw.len_sel)
      tpbm_pkg::LEN_GAP:         seg.run_length = byte_sr[0] ? cfg.one_gap : cfg.zero_gap;
      tpbm_pkg::LEN_BYTE_PAUSE:  seg.run_length = cfg.byte_pause;
      tpbm_pkg::LEN_BLOCK_PAUSE: seg.run_length = cfg.block_pause;
      default:                   seg.run_length = cfg.pulse_half;
    endcase
    unique case (cw.last_sel)
      tpbm_pkg::LAST_ALWAYS:   seg.last = 1'b1;
      tpbm_pkg::LAST_BYTE_END: seg.last = byte_end;
      default:                 seg.last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tpbm_pkg::STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

  // a second pulse is due when the count register has its high bit set
  always_ff @(posedge clk) begin
    if (take) begin
      byte_sr <= item_byte;
      bit_cnt <= '0;
      more    <= item_byte[0] ? cfg.pulses_one[1] : cfg.pulses_zero[1];
    end else if (fire && (cw.jump == tpbm_pkg::JMP_BIT_LOOP)) begin
      if (more) begin
        more <= 1'b0;
      end else if (bit_cnt != tpbm_pkg::LastBit) begin
        byte_sr <= {1'b0, byte_sr[7:1]};
        bit_cnt <= bit_cnt + 3'd1;
        more    <= byte_sr[1] ? cfg.pulses_one[1] : cfg.pulses_zero[1];
      end
    end
  end

endmodule

// ===== rtl/core/tape_pulse_byte_modulator.sv =====
// Top level: configuration registers, sequencer and output word register
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata = data_byte[7:0]; s_tuser = {block_start, func}
//  m_      | out | m_tvalid/m_tready  | m_tdata = {2'b0, run_length[19:0], level[1:0]}; m_tlast
//  cfg_    | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// A data byte takes a fetch step plus 24 to 49 segments, a pause item a fetch step and one segment;
// outside fetch the sequencer emits one segment per cycle from its single step counter while m_ does not stall.
// Reset is synchronous: step counter to fetch, output word empty, registers to defaults.
// A stalled m_ side holds the output word and freezes the step counter, but a fetch step may still take an item.
module tape_pulse_byte_modulator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  logic [1:0]                        s_tuser,   // [0] func, [1] block_start
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [23:0]                       m_tdata,   // [1:0] level, [21:2] run_length
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [tpbm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [tpbm_pkg::CountWidth-1:0]   cfg_data
);

  tpbm_pkg::cfg_t                  cfg;
  tpbm_pkg::seg_t                  seg;
  logic                            seg_free;
  logic signed [1:0]               out_level;
  logic [tpbm_pkg::CountWidth-1:0] out_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_half  <= '0;
      cfg.one_gap     <= '0;
      cfg.zero_gap    <= '0;
      cfg.pulses_one  <= 2'd2;
      cfg.pulses_zero <= 2'd1;
      cfg.byte_pause  <= '0;
      cfg.block_pause <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpbm_pkg::CfgPulseHalf:  cfg.pulse_half  <= cfg_data;
        tpbm_pkg::CfgOneGap:     cfg.one_gap     <= cfg_data;
        tpbm_pkg::CfgZeroGap:    cfg.zero_gap    <= cfg_data;
        tpbm_pkg::CfgPulsesOne:  cfg.pulses_one  <= cfg_data[1:0];
        tpbm_pkg::CfgPulsesZero: cfg.pulses_zero <= cfg_data[1:0];
        tpbm_pkg::CfgBytePause:  cfg.byte_pause  <= cfg_data;
        tpbm_pkg::CfgBlockPause: cfg.block_pause <= cfg_data;
        default: ;
      endcase
    end
  end

  tpbm_useq u_useq (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (s_tvalid),
    .item_func        (s_tuser[0]),
    .item_byte        (s_tdata),
    .item_block_start (s_tuser[1]),
    .item_ready       (s_tready),
    .cfg              (cfg),
    .seg_free         (seg_free),
    .seg              (seg)
  );

  assign seg_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (seg_free) begin
      m_tvalid <= seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_free && seg.valid) begin
      out_level <= seg.level;
      out_run   <= seg.run_length;
      m_tlast   <= seg.last;
    end
  end

  assign m_tdata = {2'b00, out_run, out_level};

endmodule

// ===== rtl/core/tpbm_checker.sv =====
// Port checker for the tape pulse byte modulator, with its bind
module tpbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'b10)
    else $error("illegal level code");

  a_neg_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == 2'b11 || m_tdata[1:0] == 2'b01) |-> !m_tlast)
    else $error("pulse half marked as last segment");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while item in progress");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind tape_pulse_byte_modulator tpbm_checker u_tpbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
